// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the chain builder core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DCB_ASSERT_IMPL(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("dcb: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DCB_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("dcb: next-cycle check failed");

`endif

// ===== hw/rtl/dcb_pkg.sv =====
`default_nettype none

package dcb_pkg;

    // Build-time limits of the chain builder.
    localparam int MAX_CHUNK_BYTES = 4096;
    localparam int MAX_CHUNKS      = 32;
    localparam int NUM_CHANNELS    = 8;

    // Field widths.
    localparam int ADDR_W   = 32;
    localparam int LEN_W    = 18;
    localparam int CH_W     = 3;
    localparam int STRIDE_W = 21;
    localparam int SIZE_W   = 9;
    localparam int IDX_W    = 16;
    localparam int BEAT_W   = 10;
    localparam int CTL_W    = 64;
    localparam int MUL_W    = STRIDE_W + IDX_W;

    // Derived constants.
    localparam logic [ADDR_W-1:0] CHUNK_BYTES32 = ADDR_W'(MAX_CHUNK_BYTES);
    localparam logic [ADDR_W-1:0] PAYLOAD_CAP32 = ADDR_W'(MAX_CHUNKS * MAX_CHUNK_BYTES - 1);
    localparam logic [BEAT_W-1:0] CHUNK_BEATS   = BEAT_W'((MAX_CHUNK_BYTES / 8) % 1024);
    localparam logic [LEN_W-1:0]  LEN_OFFSET    = LEN_W'(8);
    localparam logic [CH_W-1:0]   LAST_CHANNEL  = CH_W'(NUM_CHANNELS - 1);

    // Control words written into descriptors.
    localparam logic [CTL_W-1:0] CTL_FINAL  = 64'hc0ff_ffc0_4008_9b00;
    localparam logic [CTL_W-1:0] CTL_LINKED = 64'h80ff_ffc0_4008_9b00;

    // Configuration register indexes.
    localparam logic [1:0] REG_DESC_BASE   = 2'd0;
    localparam logic [1:0] REG_CHAN_STRIDE = 2'd1;
    localparam logic [1:0] REG_DESC_SIZE   = 2'd2;

    // Kinds of result words.
    typedef enum logic [1:0] {
        KIND_DESC  = 2'd0,
        KIND_PATCH = 2'd1,
        KIND_START = 2'd2
    } result_kind_t;

    // One result word.
    typedef struct packed {
        result_kind_t        kind;
        logic [ADDR_W-1:0]   slot_address;
        logic [ADDR_W-1:0]   chunk_dest;
        logic [ADDR_W-1:0]   chunk_source;
        logic [BEAT_W-1:0]   beat_count;
        logic [ADDR_W-1:0]   next_pointer;
        logic [CTL_W-1:0]    control_word;
        logic [CH_W-1:0]     channel_index;
        logic                last_result;
    } result_t;

    // Request to the shared multiply-add unit: acc = addend + mult_a * mult_b.
    typedef struct packed {
        logic                go;
        logic [ADDR_W-1:0]   addend;
        logic [STRIDE_W-1:0] mult_a;
        logic [IDX_W-1:0]    mult_b;
    } mac_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dcb_addr_mac.sv =====
`default_nettype none

module dcb_addr_mac
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire dcb_pkg::mac_req_t          req,
    output logic [dcb_pkg::ADDR_W-1:0]      acc
);
    import dcb_pkg::*;

    logic [MUL_W-1:0]  prod;
    logic [ADDR_W-1:0] acc_reg;
    logic [ADDR_W-1:0] acc_next;

    // Multiply-add; addresses wrap modulo 2^32.
    always_comb
    begin
        prod     = MUL_W'(req.mult_a) * MUL_W'(req.mult_b);
        acc_next = req.go ? (req.addend + prod[ADDR_W-1:0]) : acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/dcb_result_buf.sv =====
`default_nettype none

module dcb_result_buf
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push_valid,
    input  wire dcb_pkg::result_t           push_data,
    output logic                            push_ready,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [1:0]                      result_kind,
    output logic [dcb_pkg::ADDR_W-1:0]      slot_address,
    output logic [dcb_pkg::ADDR_W-1:0]      chunk_dest,
    output logic [dcb_pkg::ADDR_W-1:0]      chunk_source,
    output logic [dcb_pkg::BEAT_W-1:0]      beat_count,
    output logic [dcb_pkg::ADDR_W-1:0]      next_pointer,
    output logic [dcb_pkg::CTL_W-1:0]       control_word,
    output logic [dcb_pkg::CH_W-1:0]        channel_index,
    output logic                            last_result
);
    import dcb_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;
    result_t data_next;

    // A new word may enter when the register is empty or drains this cycle.
    assign push_ready = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (push_valid && push_ready)
        begin
            valid_next = 1'b1;
            data_next  = push_data;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            data_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            data_reg  <= data_next;
        end
    end

    // Output word fields.
    assign out_valid     = valid_reg;
    assign result_kind   = data_reg.kind;
    assign slot_address  = data_reg.slot_address;
    assign chunk_dest    = data_reg.chunk_dest;
    assign chunk_source  = data_reg.chunk_source;
    assign beat_count    = data_reg.beat_count;
    assign next_pointer  = data_reg.next_pointer;
    assign control_word  = data_reg.control_word;
    assign channel_index = data_reg.channel_index;
    assign last_result   = data_reg.last_result;

endmodule

`default_nettype wire

// ===== hw/rtl/dma_descriptor_chain_builder_core.sv =====
// A taken request runs through S_CHAN, S_CUR and S_LOAD, then S_PATCH when a round is open,
// then S_CHUNK, with an S_LINK step for every full chunk, and S_START if it ends the round.
// The patch, chunk and start words wait while the output register is full and stalled.
// The shared address multiply-add unit forms the channel area and each slot address.
// The next request is taken the cycle after the last result word enters the output register.
// Reset: config registers return to base 0, stride 4096, size 64; no round is open.
`default_nettype none

module dma_descriptor_chain_builder_core
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // Configuration write port.
    input  wire logic                       cfg_write_enable,
    input  wire logic [1:0]                 cfg_index,
    input  wire logic [dcb_pkg::ADDR_W-1:0] cfg_write_data,
    // Request channel.
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [dcb_pkg::ADDR_W-1:0] dest_address,
    input  wire logic [dcb_pkg::ADDR_W-1:0] source_address,
    input  wire logic [dcb_pkg::LEN_W-1:0]  length_bytes,
    input  wire logic                       ends_round,
    input  wire logic [dcb_pkg::CH_W-1:0]   granted_channel,
    // Result channel.
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [1:0]                      result_kind,
    output logic [dcb_pkg::ADDR_W-1:0]      slot_address,
    output logic [dcb_pkg::ADDR_W-1:0]      chunk_dest,
    output logic [dcb_pkg::ADDR_W-1:0]      chunk_source,
    output logic [dcb_pkg::BEAT_W-1:0]      beat_count,
    output logic [dcb_pkg::ADDR_W-1:0]      next_pointer,
    output logic [dcb_pkg::CTL_W-1:0]       control_word,
    output logic [dcb_pkg::CH_W-1:0]        channel_index,
    output logic                            last_result
);
    import dcb_pkg::*;

`include "assert_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHAN,
        S_CUR,
        S_LOAD,
        S_PATCH,
        S_CHUNK,
        S_LINK,
        S_START
    } state_t;

    // Configuration registers.
    logic [ADDR_W-1:0]   base_reg;
    logic [STRIDE_W-1:0] stride_reg;
    logic [SIZE_W-1:0]   size_reg;

    // Sequencer and round state.
    state_t            state_reg,        state_next;
    logic              round_open_reg,   round_open_next;
    logic [CH_W-1:0]   round_channel_reg, round_channel_next;
    logic [IDX_W-1:0]  slot_reg,         slot_next;
    logic [ADDR_W-1:0] pending_tail_reg, pending_tail_next;
    logic [ADDR_W-1:0] chan_base_reg,    chan_base_next;
    logic [ADDR_W-1:0] cur_reg,          cur_next;
    logic [ADDR_W-1:0] dst_reg,          dst_next;
    logic [ADDR_W-1:0] src_reg,          src_next;
    logic [LEN_W-1:0]  left_reg,         left_next;
    logic              ends_reg,         ends_next;
    logic              patch_reg,        patch_next;

    logic              accept;
    logic [LEN_W-1:0]  payload_raw;
    logic [LEN_W-1:0]  payload_sat;
    logic [CH_W-1:0]   channel_clamped;
    logic              full_chunk;

    mac_req_t          mac_req;
    logic [ADDR_W-1:0] mac_acc;
    logic              push_valid;
    result_t           push_data;
    logic              buf_ready;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            stride_reg <= STRIDE_W'(4096);
            size_reg   <= SIZE_W'(64);
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                REG_DESC_BASE:   base_reg   <= cfg_write_data;
                REG_CHAN_STRIDE: stride_reg <= cfg_write_data[STRIDE_W-1:0];
                REG_DESC_SIZE:   size_reg   <= cfg_write_data[SIZE_W-1:0];
                default:         base_reg   <= base_reg;
            endcase
        end
    end

    // Request decode: payload with saturation, channel clamp.
    always_comb
    begin
        payload_raw = (length_bytes >= LEN_OFFSET) ? (length_bytes - LEN_OFFSET) : '0;
        payload_sat = (ADDR_W'(payload_raw) > PAYLOAD_CAP32) ? LEN_W'(PAYLOAD_CAP32)
                                                             : payload_raw;
        channel_clamped = ({1'b0, granted_channel} >= (CH_W + 1)'(NUM_CHANNELS))
                          ? LAST_CHANNEL : granted_channel;
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign accept     = in_valid && !in_stall;
    assign full_chunk = (ADDR_W'(left_reg) >= CHUNK_BYTES32);

    // Sequencer next-state logic.
    always_comb
    begin
        state_next         = state_reg;
        round_open_next    = round_open_reg;
        round_channel_next = round_channel_reg;
        slot_next          = slot_reg;
        pending_tail_next  = pending_tail_reg;
        chan_base_next     = chan_base_reg;
        cur_next           = cur_reg;
        dst_next           = dst_reg;
        src_next           = src_reg;
        left_next          = left_reg;
        ends_next          = ends_reg;
        patch_next         = patch_reg;
        mac_req            = '0;
        push_valid         = 1'b0;
        push_data          = '0;
        push_data.channel_index = round_channel_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    dst_next   = dest_address;
                    src_next   = source_address;
                    left_next  = payload_sat;
                    ends_next  = ends_round;
                    patch_next = round_open_reg;
                    if (!round_open_reg)
                    begin
                        round_channel_next = channel_clamped;
                        slot_next          = '0;
                        round_open_next    = 1'b1;
                    end
                    else
                    begin
                        slot_next = slot_reg + IDX_W'(1);
                    end
                    state_next = S_CHAN;
                end
            end
            S_CHAN:
            begin
                // Channel area: base + channel * stride.
                mac_req.go     = 1'b1;
                mac_req.addend = base_reg;
                mac_req.mult_a = stride_reg;
                mac_req.mult_b = IDX_W'(round_channel_reg);
                state_next     = S_CUR;
            end
            S_CUR:
            begin
                // First slot of this request: channel area + size * slot.
                chan_base_next = mac_acc;
                mac_req.go     = 1'b1;
                mac_req.addend = mac_acc;
                mac_req.mult_a = STRIDE_W'(size_reg);
                mac_req.mult_b = slot_reg;
                state_next     = S_LOAD;
            end
            S_LOAD:
            begin
                cur_next   = mac_acc;
                state_next = patch_reg ? S_PATCH : S_CHUNK;
            end
            S_PATCH:
            begin
                // Link the previous round tail to this request's first slot.
                if (buf_ready)
                begin
                    push_valid             = 1'b1;
                    push_data.kind         = KIND_PATCH;
                    push_data.slot_address = pending_tail_reg;
                    push_data.next_pointer = cur_reg;
                    state_next             = S_CHUNK;
                end
            end
            S_CHUNK:
            begin
                if (full_chunk)
                begin
                    // Address of the following slot.
                    slot_next      = slot_reg + IDX_W'(1);
                    mac_req.go     = 1'b1;
                    mac_req.addend = chan_base_reg;
                    mac_req.mult_a = STRIDE_W'(size_reg);
                    mac_req.mult_b = slot_reg + IDX_W'(1);
                    state_next     = S_LINK;
                end
                else if (buf_ready)
                begin
                    // Final chunk holds the remainder and points to itself.
                    push_valid             = 1'b1;
                    push_data.kind         = KIND_DESC;
                    push_data.slot_address = cur_reg;
                    push_data.chunk_dest   = dst_reg;
                    push_data.chunk_source = src_reg;
                    push_data.beat_count   = BEAT_W'(left_reg >> 3);
                    push_data.next_pointer = cur_reg;
                    push_data.control_word = ends_reg ? CTL_FINAL : CTL_LINKED;
                    push_data.last_result  = !ends_reg;
                    if (ends_reg)
                    begin
                        state_next = S_START;
                    end
                    else
                    begin
                        pending_tail_next = cur_reg;
                        state_next        = S_IDLE;
                    end
                end
            end
            S_LINK:
            begin
                // Full chunk linked to the next slot.
                if (buf_ready)
                begin
                    push_valid             = 1'b1;
                    push_data.kind         = KIND_DESC;
                    push_data.slot_address = cur_reg;
                    push_data.chunk_dest   = dst_reg;
                    push_data.chunk_source = src_reg;
                    push_data.beat_count   = CHUNK_BEATS;
                    push_data.next_pointer = mac_acc;
                    push_data.control_word = CTL_LINKED;
                    cur_next               = mac_acc;
                    dst_next               = dst_reg + CHUNK_BYTES32;
                    src_next               = src_reg + CHUNK_BYTES32;
                    left_next              = left_reg - LEN_W'(MAX_CHUNK_BYTES);
                    state_next             = S_CHUNK;
                end
            end
            S_START:
            begin
                // Channel start points at slot zero of the round.
                if (buf_ready)
                begin
                    push_valid             = 1'b1;
                    push_data.kind         = KIND_START;
                    push_data.slot_address = chan_base_reg;
                    push_data.last_result  = 1'b1;
                    round_open_next        = 1'b0;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            round_open_reg    <= 1'b0;
            round_channel_reg <= '0;
            slot_reg          <= '0;
            pending_tail_reg  <= '0;
            chan_base_reg     <= '0;
            cur_reg           <= '0;
            dst_reg           <= '0;
            src_reg           <= '0;
            left_reg          <= '0;
            ends_reg          <= 1'b0;
            patch_reg         <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            round_open_reg    <= round_open_next;
            round_channel_reg <= round_channel_next;
            slot_reg          <= slot_next;
            pending_tail_reg  <= pending_tail_next;
            chan_base_reg     <= chan_base_next;
            cur_reg           <= cur_next;
            dst_reg           <= dst_next;
            src_reg           <= src_next;
            left_reg          <= left_next;
            ends_reg          <= ends_next;
            patch_reg         <= patch_next;
        end
    end

    // Shared slot address unit.
    dcb_addr_mac u_addr_mac
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mac_req),
        .acc     (mac_acc)
    );

    // Output register.
    dcb_result_buf u_result_buf
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push_valid    (push_valid),
        .push_data     (push_data),
        .push_ready    (buf_ready),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_kind   (result_kind),
        .slot_address  (slot_address),
        .chunk_dest    (chunk_dest),
        .chunk_source  (chunk_source),
        .beat_count    (beat_count),
        .next_pointer  (next_pointer),
        .control_word  (control_word),
        .channel_index (channel_index),
        .last_result   (last_result)
    );

    // The sequencer only writes the output register when it has room.
    `DCB_ASSERT_IMPL(a_push_has_room, clk, rst_n, push_valid, buf_ready)
    // A taken request always begins with the channel area computation.
    `DCB_ASSERT_NEXT(a_accept_starts, clk, rst_n, accept, state_reg == S_CHAN)
    // A link patch always targets the tail left by the previous request.
    `DCB_ASSERT_IMPL(a_patch_tail, clk, rst_n, push_valid && push_data.kind == KIND_PATCH,
        push_data.slot_address == pending_tail_reg)
    // A channel start closes the round.
    `DCB_ASSERT_NEXT(a_start_closes, clk, rst_n, push_valid && push_data.kind == KIND_START,
        !round_open_reg && state_reg == S_IDLE)

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;

    import dcb_pkg::*;

    // The block only decodes indexes 0 to 2; a write to this one must change nothing.
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int TIMEOUT_CYCLES = 3_000_000;

    // Tracks the open round and the descriptor slots, and holds the words still owed.
    class chain_scoreboard;
        logic [ADDR_W-1:0]   base_address = '0;
        logic [STRIDE_W-1:0] channel_stride = STRIDE_W'(4096);
        logic [SIZE_W-1:0]   slot_size = SIZE_W'(64);
        logic                round_open = 1'b0;
        logic [CH_W-1:0]     round_channel = '0;
        logic [IDX_W-1:0]    slot_index = '0;
        logic [ADDR_W-1:0]   tail_address = '0;
        result_t             awaited_words[$];
        int                  errors = 0;

        function void write_reg(logic [1:0] index, logic [31:0] data);
            case (index)
                REG_DESC_BASE:   base_address = data;
                REG_CHAN_STRIDE: channel_stride = data[STRIDE_W-1:0];
                REG_DESC_SIZE:   slot_size = data[SIZE_W-1:0];
                default:         ;
            endcase
        endfunction

        function int pending();
            return awaited_words.size();
        endfunction

        // Address of one slot, wrapping modulo 2^32.
        function logic [ADDR_W-1:0] slot_of(logic [CH_W-1:0] ch, logic [IDX_W-1:0] idx);
            logic [63:0] sum;
            sum = 64'(base_address) + 64'(ch) * 64'(channel_stride)
                + 64'(slot_size) * 64'(idx);
            return sum[ADDR_W-1:0];
        endfunction

        function result_t word_of(result_kind_t kind, logic [ADDR_W-1:0] slot,
                                  logic [ADDR_W-1:0] dst, logic [ADDR_W-1:0] src,
                                  logic [BEAT_W-1:0] beats, logic [ADDR_W-1:0] next,
                                  logic [CTL_W-1:0] ctl);
            result_t w;
            w.kind = kind;
            w.slot_address = slot;
            w.chunk_dest = dst;
            w.chunk_source = src;
            w.beat_count = beats;
            w.next_pointer = next;
            w.control_word = ctl;
            w.channel_index = round_channel;
            w.last_result = 1'b0;
            return w;
        endfunction

        // Works out every word that one accepted request causes.
        function void take_request(logic [ADDR_W-1:0] dst, logic [ADDR_W-1:0] src,
                                   logic [LEN_W-1:0] len, logic ends, logic [CH_W-1:0] gch);
            logic [31:0] payload;
            logic [31:0] chunks;
            logic [31:0] left;
            logic [ADDR_W-1:0] cur;
            logic [ADDR_W-1:0] nxt;
            logic [ADDR_W-1:0] d;
            logic [ADDR_W-1:0] s;
            d = dst;
            s = src;
            payload = (len >= LEN_OFFSET) ? 32'(len - LEN_OFFSET) : 32'd0;
            if (payload > PAYLOAD_CAP32)
                payload = PAYLOAD_CAP32;
            chunks = payload / CHUNK_BYTES32 + 32'd1;

            // A new round takes the granted channel; an open round is first linked on.
            if (!round_open) begin
                if (32'(gch) >= 32'(NUM_CHANNELS))
                    gch = LAST_CHANNEL;
                round_channel = gch;
                slot_index = '0;
                round_open = 1'b1;
                cur = slot_of(round_channel, slot_index);
            end
            else begin
                slot_index = slot_index + 16'd1;
                cur = slot_of(round_channel, slot_index);
                awaited_words.push_back(word_of(KIND_PATCH, tail_address, '0, '0, '0, cur, '0));
            end

            // Full chunks, each pointing at the next slot.
            left = payload;
            repeat (chunks - 1) begin
                slot_index = slot_index + 16'd1;
                nxt = slot_of(round_channel, slot_index);
                awaited_words.push_back(word_of(KIND_DESC, cur, d, s, CHUNK_BEATS, nxt,
                                                CTL_LINKED));
                d = d + CHUNK_BYTES32;
                s = s + CHUNK_BYTES32;
                left = left - CHUNK_BYTES32;
                cur = nxt;
            end

            // The remainder chunk points at itself.
            awaited_words.push_back(word_of(KIND_DESC, cur, d, s, BEAT_W'(left >> 3), cur,
                                            ends ? CTL_FINAL : CTL_LINKED));
            if (ends) begin
                awaited_words.push_back(word_of(KIND_START, slot_of(round_channel, '0),
                                                '0, '0, '0, '0, '0));
                round_open = 1'b0;
            end
            else begin
                tail_address = cur;
            end
            awaited_words[awaited_words.size() - 1].last_result = 1'b1;
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_word(result_t got);
            result_t want;
            if (awaited_words.size() == 0) begin
                $error("result word with nothing awaited: kind %0d, slot 0x%0h",
                       got.kind, got.slot_address);
                errors++;
                return;
            end
            want = awaited_words.pop_front();
            compare_field("result_kind", 64'(want.kind), 64'(got.kind));
            compare_field("slot_address", 64'(want.slot_address), 64'(got.slot_address));
            compare_field("chunk_dest", 64'(want.chunk_dest), 64'(got.chunk_dest));
            compare_field("chunk_source", 64'(want.chunk_source), 64'(got.chunk_source));
            compare_field("beat_count", 64'(want.beat_count), 64'(got.beat_count));
            compare_field("next_pointer", 64'(want.next_pointer), 64'(got.next_pointer));
            compare_field("control_word", want.control_word, got.control_word);
            compare_field("channel_index", 64'(want.channel_index), 64'(got.channel_index));
            compare_field("last_result", 64'(want.last_result), 64'(got.last_result));
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_write_enable;
    logic [1:0]          cfg_index;
    logic [ADDR_W-1:0]   cfg_write_data;
    logic                in_valid;
    logic                in_stall;
    logic [ADDR_W-1:0]   dest_address;
    logic [ADDR_W-1:0]   source_address;
    logic [LEN_W-1:0]    length_bytes;
    logic                ends_round;
    logic [CH_W-1:0]     granted_channel;
    logic                out_valid;
    logic                out_stall;
    logic [1:0]          result_kind;
    logic [ADDR_W-1:0]   slot_address;
    logic [ADDR_W-1:0]   chunk_dest;
    logic [ADDR_W-1:0]   chunk_source;
    logic [BEAT_W-1:0]   beat_count;
    logic [ADDR_W-1:0]   next_pointer;
    logic [CTL_W-1:0]    control_word;
    logic [CH_W-1:0]     channel_index;
    logic                last_result;

    // Both sides run without gaps while this is set.
    bit                  calm = 1'b0;
    // Asks the receiver for one long hold-off.
    bit                  hold_request = 1'b0;
    chain_scoreboard     sb = new();
    result_t             seen_word;

    dma_descriptor_chain_builder_core uut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .dest_address     (dest_address),
        .source_address   (source_address),
        .length_bytes     (length_bytes),
        .ends_round       (ends_round),
        .granted_channel  (granted_channel),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .result_kind      (result_kind),
        .slot_address     (slot_address),
        .chunk_dest       (chunk_dest),
        .chunk_source     (chunk_source),
        .beat_count       (beat_count),
        .next_pointer     (next_pointer),
        .control_word     (control_word),
        .channel_index    (channel_index),
        .last_result      (last_result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Every word taken from the block is checked against the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) begin
            seen_word.kind = result_kind_t'(result_kind);
            seen_word.slot_address = slot_address;
            seen_word.chunk_dest = chunk_dest;
            seen_word.chunk_source = chunk_source;
            seen_word.beat_count = beat_count;
            seen_word.next_pointer = next_pointer;
            seen_word.control_word = control_word;
            seen_word.channel_index = channel_index;
            seen_word.last_result = last_result;
            sb.check_word(seen_word);
        end
    end

    // Receiver: single stall cycles, occasional runs, and one long hold-off on request.
    initial
    begin
        int unsigned roll;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                out_stall = 1'b1;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                out_stall = 1'b0;
            end
            else if (calm) begin
                out_stall = 1'b0;
            end
            else begin
                roll = $urandom_range(0, 99);
                if (roll < 3) begin
                    out_stall = 1'b1;
                    repeat ($urandom_range(8, 40)) @(negedge clk);
                    out_stall = 1'b0;
                end
                else begin
                    out_stall = (roll < 28);
                end
            end
        end
    end

    // Drops valid for some cycles and scrambles the idle payload meanwhile.
    task automatic idle_sender(int unsigned cycles);
        if (cycles != 0) begin
            @(negedge clk);
            in_valid = 1'b0;
            dest_address = $urandom();
            source_address = $urandom();
            length_bytes = LEN_W'($urandom());
            ends_round = 1'(($urandom()));
            granted_channel = CH_W'($urandom());
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    task automatic send_request(logic [ADDR_W-1:0] dst, logic [ADDR_W-1:0] src,
                                logic [LEN_W-1:0] len, logic ends, logic [CH_W-1:0] gch);
        @(negedge clk);
        dest_address = dst;
        source_address = src;
        length_bytes = len;
        ends_round = ends;
        granted_channel = gch;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.take_request(dst, src, len, ends, gch);
    endtask

    // Stops offering and waits until every owed word has come back.
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] index, logic [31:0] data);
        @(negedge clk);
        cfg_write_enable = 1'b1;
        cfg_index = index;
        cfg_write_data = data;
        sb.write_reg(index, data);
        @(posedge clk);
    endtask

    task automatic load_config(logic [31:0] base, logic [31:0] stride, logic [31:0] size);
        write_register(REG_DESC_BASE, base);
        write_register(REG_CHAN_STRIDE, stride);
        write_register(REG_DESC_SIZE, size);
        @(negedge clk);
        cfg_write_enable = 1'b0;
    endtask

    // Random requests: mostly short transfers, some long, a few at the length extremes.
    task automatic run_random(int unsigned count);
        int unsigned roll;
        logic [ADDR_W-1:0] dst;
        logic [ADDR_W-1:0] src;
        logic [LEN_W-1:0] len;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (calm || roll < 60)
                idle_sender(0);
            else if (roll < 92)
                idle_sender($urandom_range(1, 3));
            else
                idle_sender($urandom_range(10, 30));

            roll = $urandom_range(0, 99);
            if (roll < 55)
                len = LEN_W'($urandom_range(8, 8 + 8192));
            else if (roll < 80)
                len = LEN_W'($urandom_range(8, 131079));
            else if (roll < 85)
                len = LEN_W'($urandom_range(0, 7));
            else if (roll < 90)
                len = LEN_W'($urandom_range(131079, 131081));
            else
                len = LEN_W'($urandom());

            dst = $urandom();
            src = $urandom();
            // Addresses close to the top of the space wrap within a transfer.
            if ($urandom_range(0, 9) == 0) begin
                dst = 32'hFFFF_0000 | ADDR_W'($urandom_range(0, 16'hFFFF));
                src = 32'hFFFF_0000 | ADDR_W'($urandom_range(0, 16'hFFFF));
            end
            send_request(dst, src, len, $urandom_range(0, 99) < 30, CH_W'($urandom()));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_index = REG_DESC_BASE;
        cfg_write_data = '0;
        in_valid = 1'b0;
        dest_address = '0;
        source_address = '0;
        length_bytes = '0;
        ends_round = 1'b0;
        granted_channel = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Directed requests under the reset configuration.
        calm = 1'b1;
        send_request(32'h0000_0000, 32'h0000_0000, 18'd8, 1'b1, 3'd0);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 18'd0, 1'b0, 3'd7);
        send_request(32'h1234_5678, 32'h8765_4321, 18'd7, 1'b0, 3'd2);
        send_request(32'hFFFF_F800, 32'h0000_1000, 18'd4104, 1'b0, 3'd5);
        send_request(32'h0000_0008, 32'h0000_0010, 18'd4103, 1'b1, 3'd1);
        send_request(32'hFFFF_0000, 32'h7FFF_FFFF, 18'd131079, 1'b0, 3'd3);
        send_request(32'h0000_1000, 32'hFFFF_F000, 18'd131080, 1'b0, 3'd0);
        send_request(32'hFFFF_FFF8, 32'h0000_0000, 18'h3FFFF, 1'b1, 3'd6);
        send_request(32'hAAAA_AAAA, 32'h5555_5555, 18'h15555, 1'b1, 3'd4);
        send_request(32'h5555_5555, 32'hAAAA_AAAA, 18'h2AAAA, 1'b0, 3'd1);
        send_request(32'h0000_0100, 32'h0000_0200, 18'd16, 1'b1, 3'd7);
        for (int ch = 0; ch < NUM_CHANNELS; ch++)
            send_request($urandom(), $urandom(), LEN_W'(8 + 8 * ch), 1'b1, CH_W'(ch));
        calm = 1'b0;
        drain_results();

        // Largest register values, with a write to the undecoded index first.
        write_register(REG_UNUSED, $urandom());
        load_config(32'hFFFF_FF00, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_random(72);
        drain_results();

        // All registers zero; the first half runs without any idling.
        load_config(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        calm = 1'b1;
        run_random(36);
        calm = 1'b0;
        run_random(36);
        drain_results();

        // Random settings; the receiver holds off long while requests keep coming.
        load_config($urandom(), $urandom_range(0, 1048576), $urandom_range(8, 256));
        hold_request = 1'b1;
        run_random(72);
        drain_results();

        // Stride 1048576 and slot size 256; the sender waits out every result halfway through.
        load_config($urandom(), 32'd1048576, 32'd256);
        run_random(36);
        drain_results();
        run_random(36);
        drain_results();

        // Slot size 8.
        load_config($urandom(), $urandom_range(0, 1048576), 32'd8);
        run_random(72);
        drain_results();

        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial
    begin
        repeat (TIMEOUT_CYCLES) @(posedge clk);
        $display("tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
